@@ rtl/sapd_pkg.sv @@
// Shared types and constants for the source address packet dropper.
package sapd_pkg;

	localparam logic [15:0] ETYPE_VLAN_Q  = 16'h8100;
	localparam logic [15:0] ETYPE_VLAN_AD = 16'h88a8;
	localparam logic [15:0] PROTO_IPV4    = 16'h0800;
	localparam logic [15:0] PROTO_IPV6    = 16'h86dd;
	localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
	localparam logic [15:0] VLAN_HDR_LEN  = 16'd4;
	localparam logic [15:0] IPV4_HDR_LEN  = 16'd20;
	localparam logic [15:0] IPV6_HDR_LEN  = 16'd40;
	localparam logic [15:0] ETYPE_POS_HI  = 16'd12;
	localparam logic [15:0] ETYPE_POS_LO  = 16'd13;
	localparam logic [15:0] POS_MAX       = 16'hffff;
	localparam logic [15:0] THRESH_RESET  = 16'd450;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE = 3'd0,
		REG_ADDR_A_HIGH   = 3'd1,
		REG_ADDR_A_LOW    = 3'd2,
		REG_ADDR_B_HIGH   = 3'd3,
		REG_ADDR_B_LOW    = 3'd4,
		REG_LEN_THRESHOLD = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		V_PASS  = 2'd0,
		V_TRUNC = 2'd1,
		V_MATCH = 2'd2
	} verdict_t;

	typedef struct packed {
		logic        filter_enable;
		logic [63:0] addr_a_high;
		logic [63:0] addr_a_low;
		logic [63:0] addr_b_high;
		logic [63:0] addr_b_low;
		logic [15:0] length_threshold;
	} cfg_t;

	typedef struct packed {
		logic [15:0] byte_position;
		logic [15:0] protocol;
		logic        vlan_seen;
		logic [63:0] source_high;
		logic [63:0] source_low;
	} frame_state_t;

endpackage

@@ rtl/sapd_ifs.sv @@
// Channel interfaces: byte input, verdict output, register write.
interface sapd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        first_byte;
	logic        last_byte;
	logic [15:0] frame_protocol;

	modport source(output valid, data_byte, first_byte, last_byte, frame_protocol,
		input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, frame_protocol,
		output ready);
endinterface

interface sapd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [31:0] drop_total;

	modport source(output valid, verdict, drop_total, input ready);
	modport sink(input valid, verdict, drop_total, output ready);
endinterface

interface sapd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/sapd_cfg_regs.sv @@
// Configuration register file with index decode.
module sapd_cfg_regs
	import sapd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [63:0]       wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_enable    <= 1'b1;
			cfg_q.addr_a_high      <= '0;
			cfg_q.addr_a_low       <= '0;
			cfg_q.addr_b_high      <= '0;
			cfg_q.addr_b_low       <= '0;
			cfg_q.length_threshold <= THRESH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FILTER_ENABLE: cfg_q.filter_enable    <= wr_data[0];
				REG_ADDR_A_HIGH:   cfg_q.addr_a_high      <= wr_data;
				REG_ADDR_A_LOW:    cfg_q.addr_a_low       <= wr_data;
				REG_ADDR_B_HIGH:   cfg_q.addr_b_high      <= wr_data;
				REG_ADDR_B_LOW:    cfg_q.addr_b_low       <= wr_data;
				REG_LEN_THRESHOLD: cfg_q.length_threshold <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/sapd_parser.sv @@
// Per-frame header tracking: byte position, VLAN skip, source address capture.
module sapd_parser
	import sapd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         advance,
	input  logic [7:0]   data_byte,
	input  logic         first_byte,
	input  logic         last_byte,
	input  logic [15:0]  frame_protocol,
	output frame_state_t state_next
);

	frame_state_t st_q;
	frame_state_t st_e;
	frame_state_t st_n;
	logic [15:0]  etype_q;
	logic [15:0]  etype_e;
	logic [15:0]  etype_n;
	logic [15:0]  idx;
	logic [15:0]  nh;

	always_comb begin
		st_e    = st_q;
		etype_e = etype_q;
		if (first_byte) begin
			st_e.byte_position = '0;
			st_e.vlan_seen     = 1'b0;
			st_e.source_high   = '0;
			st_e.source_low    = '0;
			st_e.protocol      = frame_protocol;
			etype_e            = '0;
		end
		idx = st_e.byte_position;
		nh  = st_e.vlan_seen ? (ETH_HDR_LEN + VLAN_HDR_LEN) : ETH_HDR_LEN;

		st_n    = st_e;
		etype_n = etype_e;
		if (idx == ETYPE_POS_HI || idx == ETYPE_POS_LO) begin
			etype_n = {etype_e[7:0], data_byte};
			if (idx == ETYPE_POS_LO)
				st_n.vlan_seen = (etype_n == ETYPE_VLAN_Q) || (etype_n == ETYPE_VLAN_AD);
		end else if (idx >= ETH_HDR_LEN) begin
			if (st_e.protocol == PROTO_IPV4) begin
				if (idx >= 16'(nh + 16'd12) && idx <= 16'(nh + 16'd15))
					st_n.source_low = {32'b0, st_e.source_low[23:0], data_byte};
			end else if (st_e.protocol == PROTO_IPV6) begin
				if (idx >= 16'(nh + 16'd8) && idx <= 16'(nh + 16'd15))
					st_n.source_high = {st_e.source_high[55:0], data_byte};
				else if (idx >= 16'(nh + 16'd16) && idx <= 16'(nh + 16'd23))
					st_n.source_low = {st_e.source_low[55:0], data_byte};
			end
		end
		if (st_e.byte_position != POS_MAX)
			st_n.byte_position = 16'(st_e.byte_position + 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			etype_q <= '0;
		end else if (advance) begin
			if (last_byte) begin
				st_q          <= '0;
				st_q.protocol <= st_n.protocol;
				etype_q       <= '0;
			end else begin
				st_q    <= st_n;
				etype_q <= etype_n;
			end
		end
	end

	assign state_next = st_n;

	a_pos_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_byte |=> st_q.byte_position == '0 && !st_q.vlan_seen)
		else $error("frame state not cleared after last byte");

	a_pos_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_byte && !first_byte && st_q.byte_position != POS_MAX
		|=> st_q.byte_position == 16'($past(st_q.byte_position) + 16'd1))
		else $error("byte position did not advance");

endmodule

@@ rtl/sapd_judge.sv @@
// Frame verdict and saturating matched-drop counter.
module sapd_judge
	import sapd_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         commit,
	input  cfg_t         cfg,
	input  frame_state_t st,
	output verdict_t     verdict,
	output logic [31:0]  drop_total
);

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] cnt_n;
	logic [15:0]            len;
	logic [15:0]            nh;
	logic                   is_v4;
	logic                   is_v6;
	logic                   match;

	always_comb begin
		len   = st.byte_position;
		nh    = st.vlan_seen ? (ETH_HDR_LEN + VLAN_HDR_LEN) : ETH_HDR_LEN;
		is_v4 = st.protocol == PROTO_IPV4;
		is_v6 = st.protocol == PROTO_IPV6;
		if (is_v4)
			match = (st.source_low[31:0] == cfg.addr_a_low[31:0]) ||
				(st.source_low[31:0] == cfg.addr_b_low[31:0]);
		else
			match = (st.source_high == cfg.addr_a_high && st.source_low == cfg.addr_a_low) ||
				(st.source_high == cfg.addr_b_high && st.source_low == cfg.addr_b_low);

		if (!cfg.filter_enable || (!is_v4 && !is_v6))
			verdict = V_PASS;
		else if (len < nh)
			verdict = V_TRUNC;
		else if (is_v4 && len < 16'(nh + IPV4_HDR_LEN))
			verdict = V_TRUNC;
		else if (is_v6 && len < 16'(nh + IPV6_HDR_LEN))
			verdict = V_TRUNC;
		else if (match && len >= cfg.length_threshold)
			verdict = V_MATCH;
		else
			verdict = V_PASS;

		cnt_n = cnt_q;
		if (verdict == V_MATCH && cnt_q != '1)
			cnt_n = cnt_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (commit)
			cnt_q <= cnt_n;
	end

	assign drop_total = 32'(cnt_n);

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit && verdict == V_MATCH |=>
		cnt_q == $past(cnt_q) + 1'b1 || $past(cnt_q) == '1)
		else $error("matched drop not counted");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && verdict == V_MATCH) |=> cnt_q == $past(cnt_q))
		else $error("drop counter moved without a matched drop");

endmodule

@@ rtl/source_address_packet_dropper.sv @@
// Top level: input register, header parser, verdict logic, output register.
// Throughput: one byte per cycle, sustained, with the output side ready.
// A frame's verdict passes through the input register, then the result register
// (the verdict logic sits between them).
// A held result stalls input only when the staged byte is a last byte.
// Reset clears frame state, protocol tag, drop counter and loads register defaults.
module source_address_packet_dropper
	import sapd_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	sapd_in_if.sink     in_ch,
	sapd_out_if.source  out_ch,
	sapd_cfg_if.sink    cfg_ch
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         first_s1;
	logic         last_s1;
	logic [15:0]  proto_s1;
	logic         advance;
	logic         out_valid_q;
	logic [1:0]   verdict_q;
	logic [31:0]  total_q;
	cfg_t         cfg;
	frame_state_t st_next;
	verdict_t     verdict;
	logic [31:0]  drop_total;

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign cfg_ch.ready = 1'b1;

	sapd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_ch.valid),
		.wr_index (cfg_ch.index),
		.wr_data  (cfg_ch.data),
		.cfg      (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1  <= in_ch.data_byte;
			first_s1 <= in_ch.first_byte;
			last_s1  <= in_ch.last_byte;
			proto_s1 <= in_ch.frame_protocol;
		end
	end

	sapd_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.data_byte      (data_s1),
		.first_byte     (first_s1),
		.last_byte      (last_s1),
		.frame_protocol (proto_s1),
		.state_next     (st_next)
	);

	sapd_judge #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (advance && last_s1),
		.cfg        (cfg),
		.st         (st_next),
		.verdict    (verdict),
		.drop_total (drop_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && last_s1)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict;
			total_q   <= drop_total;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.verdict    = verdict_q;
	assign out_ch.drop_total = total_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |-> !(advance && last_s1))
		else $error("pending result overwritten");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1) && $stable(last_s1))
		else $error("staged byte lost while stalled");

endmodule

@@ verif/source_address_packet_dropper_test.sv @@
// Testbench for the source address packet dropper: frame stimulus, verdict prediction, checks.
module source_address_packet_dropper_test
	import sapd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT = 60000;
	localparam logic [15:0] PROTO_OTHER = 16'h1234;

	typedef struct {
		logic [7:0]  data_b;
		logic        first_b;
		logic        last_b;
		logic [15:0] proto;
	} byte_xfer_t;

	typedef struct {
		verdict_t    verdict;
		logic [31:0] drop_total;
	} verdict_rec_t;

	class verdict_scoreboard;
		logic        filter_en;
		logic [63:0] a_hi, a_lo, b_hi, b_lo;
		logic [15:0] thresh;
		logic [15:0] pos, proto, etype;
		logic        vlan;
		logic [63:0] src_hi, src_lo;
		logic [31:0] drops;
		verdict_rec_t pending_verdicts[$];
		int errors;

		function void clear_frame();
			pos = '0;
			etype = '0;
			vlan = 1'b0;
			src_hi = '0;
			src_lo = '0;
		endfunction

		function void load_reset();
			filter_en = 1'b1;
			a_hi = '0;
			a_lo = '0;
			b_hi = '0;
			b_lo = '0;
			thresh = THRESH_RESET;
			proto = '0;
			drops = '0;
			errors = 0;
			clear_frame();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
			case (idx)
				REG_FILTER_ENABLE: filter_en = value[0];
				REG_ADDR_A_HIGH:   a_hi = value;
				REG_ADDR_A_LOW:    a_lo = value;
				REG_ADDR_B_HIGH:   b_hi = value;
				REG_ADDR_B_LOW:    b_lo = value;
				REG_LEN_THRESHOLD: thresh = value[15:0];
				default: ;
			endcase
		endfunction

		function verdict_t judge(logic [15:0] len);
			int  nh;
			bit  hit;
			nh = ETH_HDR_LEN;
			if (!filter_en)
				return V_PASS;
			if (proto != PROTO_IPV4 && proto != PROTO_IPV6)
				return V_PASS;
			if (len < ETH_HDR_LEN)
				return V_TRUNC;
			if (vlan) begin
				nh += VLAN_HDR_LEN;
				if (len < nh)
					return V_TRUNC;
			end
			if (proto == PROTO_IPV4) begin
				if (len < nh + IPV4_HDR_LEN)
					return V_TRUNC;
				hit = src_lo[31:0] == a_lo[31:0] || src_lo[31:0] == b_lo[31:0];
			end else begin
				if (len < nh + IPV6_HDR_LEN)
					return V_TRUNC;
				hit = (src_hi == a_hi && src_lo == a_lo) || (src_hi == b_hi && src_lo == b_lo);
			end
			if (!hit || len < thresh)
				return V_PASS;
			if (drops != '1)
				drops++;
			return V_MATCH;
		endfunction

		function void note_byte(byte_xfer_t x);
			int nh;
			verdict_rec_t rec;
			if (x.first_b) begin
				clear_frame();
				proto = x.proto;
			end
			nh = ETH_HDR_LEN + (vlan ? VLAN_HDR_LEN : 16'd0);
			if (pos == ETYPE_POS_HI || pos == ETYPE_POS_LO) begin
				etype = {etype[7:0], x.data_b};
				if (pos == ETYPE_POS_LO)
					vlan = etype == ETYPE_VLAN_Q || etype == ETYPE_VLAN_AD;
			end else if (pos >= ETH_HDR_LEN) begin
				if (proto == PROTO_IPV4) begin
					if (pos >= nh + 12 && pos <= nh + 15)
						src_lo = {32'd0, src_lo[23:0], x.data_b};
				end else if (proto == PROTO_IPV6) begin
					if (pos >= nh + 8 && pos <= nh + 15)
						src_hi = {src_hi[55:0], x.data_b};
					else if (pos >= nh + 16 && pos <= nh + 23)
						src_lo = {src_lo[55:0], x.data_b};
				end
			end
			if (pos != POS_MAX)
				pos++;
			if (x.last_b) begin
				rec.verdict = judge(pos);
				rec.drop_total = drops;
				pending_verdicts.push_back(rec);
				clear_frame();
			end
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task check_verdict(logic [1:0] verdict, logic [31:0] drop_total);
			verdict_rec_t rec;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("unexpected verdict %0d, drop_total %0d", verdict, drop_total));
				return;
			end
			rec = pending_verdicts.pop_front();
			if (verdict !== rec.verdict)
				report($sformatf("verdict %0d, want %0d", verdict, rec.verdict));
			if (drop_total !== rec.drop_total)
				report($sformatf("drop_total %0d, want %0d", drop_total, rec.drop_total));
		endtask
	endclass

	logic clk;
	logic arst_n;

	sapd_in_if  in_ch();
	sapd_out_if out_ch();
	sapd_cfg_if cfg_ch();

	source_address_packet_dropper dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	verdict_scoreboard sb;
	byte_xfer_t frame_bytes[$];
	int in_idle_pct;
	int out_stall_pct;
	int hold_left;
	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= $urandom_range(99) >= out_stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_verdict(out_ch.verdict, out_ch.drop_total);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic void build_frame(input logic [15:0] proto, input logic [15:0] etype,
			input int len, input logic [63:0] s_hi, input logic [63:0] s_lo, input bit with_first);
		int nh;
		byte_xfer_t x;
		frame_bytes.delete();
		nh = (etype == ETYPE_VLAN_Q || etype == ETYPE_VLAN_AD) ? 18 : 14;
		for (int i = 0; i < len; i++) begin
			x.data_b = 8'($urandom);
			if (i == 12)
				x.data_b = etype[15:8];
			else if (i == 13)
				x.data_b = etype[7:0];
			else if (proto == PROTO_IPV4 && i >= nh + 12 && i <= nh + 15)
				x.data_b = s_lo[8 * (nh + 15 - i) +: 8];
			else if (proto == PROTO_IPV6 && i >= nh + 8 && i <= nh + 15)
				x.data_b = s_hi[8 * (nh + 15 - i) +: 8];
			else if (proto == PROTO_IPV6 && i >= nh + 16 && i <= nh + 23)
				x.data_b = s_lo[8 * (nh + 23 - i) +: 8];
			x.first_b = with_first && i == 0;
			x.last_b = i == len - 1;
			x.proto = x.first_b ? proto : 16'($urandom);
			frame_bytes.push_back(x);
		end
	endfunction

	task send_byte(input byte_xfer_t x);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= x.data_b;
		in_ch.first_byte <= x.first_b;
		in_ch.last_byte <= x.last_b;
		in_ch.frame_protocol <= x.proto;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_byte(x);
	endtask

	task send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i]);
	endtask

	task frame(input logic [15:0] proto, input logic [15:0] etype, input int len,
			input logic [63:0] s_hi, input logic [63:0] s_lo, input bit with_first);
		build_frame(proto, etype, len, s_hi, s_lo, with_first);
		send_frame();
	endtask

	task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// sender quiet until all verdicts are in, then let the pipeline empty
	task wait_idle();
		in_ch.valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task configure_phase(input int ph);
		logic [63:0] v;
		logic [15:0] thr;
		logic [63:0] ahi, alo;
		v = rand64();
		write_register(REG_FILTER_ENABLE, {v[63:1], 1'b1});
		ahi = rand64();
		alo = rand64();
		write_register(REG_ADDR_A_HIGH, ahi);
		write_register(REG_ADDR_A_LOW, alo);
		if (ph % 2) begin
			write_register(REG_ADDR_B_HIGH, ahi);
			write_register(REG_ADDR_B_LOW, alo ^ (64'd1 << $urandom_range(63)));
		end else begin
			write_register(REG_ADDR_B_HIGH, rand64());
			write_register(REG_ADDR_B_LOW, rand64());
		end
		case (ph)
			0: thr = 16'd0;
			1: thr = 16'd34;
			2: thr = 16'd58;
			default: thr = 16'($urandom_range(80));
		endcase
		v = rand64();
		write_register(REG_LEN_THRESHOLD, {v[63:16], thr});
	endtask

	task random_frame();
		int r, nh, need, len;
		bit with_first;
		logic [15:0] proto, etype;
		logic [63:0] s_hi, s_lo;
		with_first = $urandom_range(9) != 0;
		if ($urandom_range(99) < 8) begin
			build_frame(16'($urandom), 16'($urandom), $urandom_range(1, 20), rand64(), rand64(),
				1'($urandom_range(1)));
			frame_bytes[frame_bytes.size() - 1].last_b = 1'b0;
			send_frame();
			with_first = 1'b1;
		end
		r = $urandom_range(99);
		proto = r < 40 ? PROTO_IPV4 : r < 75 ? PROTO_IPV6 : 16'($urandom);
		r = $urandom_range(99);
		if (r < 25)
			etype = ETYPE_VLAN_Q;
		else if (r < 40)
			etype = ETYPE_VLAN_AD;
		else if (r < 45)
			etype = ETYPE_VLAN_Q ^ 16'h0001;
		else if (r < 50)
			etype = ETYPE_VLAN_AD ^ 16'h0100;
		else
			etype = 16'($urandom);
		nh = (etype == ETYPE_VLAN_Q || etype == ETYPE_VLAN_AD) ? 18 : 14;
		need = nh + (proto == PROTO_IPV6 ? IPV6_HDR_LEN : IPV4_HDR_LEN);
		r = $urandom_range(99);
		if (r < 15)
			len = $urandom_range(1, nh + 2);
		else if (r < 30)
			len = need - 1;
		else if (r < 85)
			len = need + $urandom_range(4);
		else if (r < 95 || sb.thresh == 0 || sb.thresh > 600)
			len = $urandom_range(need, 120);
		else
			len = sb.thresh - 1 + $urandom_range(2);
		r = $urandom_range(99);
		if (r < 35) begin
			s_hi = sb.a_hi;
			s_lo = sb.a_lo;
		end else if (r < 65) begin
			s_hi = sb.b_hi;
			s_lo = sb.b_lo;
		end else if (r < 75) begin
			s_hi = sb.a_hi;
			s_lo = sb.b_lo;
		end else if (r < 85) begin
			s_hi = sb.a_hi;
			s_lo = sb.a_lo;
			if ($urandom_range(1))
				s_lo ^= 64'd1 << $urandom_range(31);
			else
				s_hi ^= 64'd1 << $urandom_range(63);
		end else begin
			s_hi = rand64();
			s_lo = rand64();
		end
		frame(proto, etype, len, s_hi, s_lo, with_first);
	endtask

	initial begin
		sb = new;
		sb.load_reset();
		cycles = 0;
		hold_left = 0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.first_byte <= 1'b0;
		in_ch.last_byte <= 1'b0;
		in_ch.frame_protocol <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: watched addresses zero, threshold 450
		frame(16'($urandom), 16'($urandom), 6, rand64(), rand64(), 1'b0);
		frame(PROTO_IPV4, PROTO_IPV4, 1, '0, '0, 1'b1);
		frame(PROTO_IPV4, PROTO_IPV4, 13, '0, '0, 1'b1);
		frame(PROTO_IPV4, PROTO_IPV4, 33, '0, '0, 1'b1);
		frame(PROTO_IPV6, ETYPE_VLAN_AD, 17, '0, '0, 1'b1);
		frame(PROTO_OTHER, PROTO_IPV4, 20, '0, '0, 1'b1);
		build_frame(PROTO_IPV6, PROTO_IPV6, 6, '0, '0, 1'b1);
		frame_bytes[5].last_b = 1'b0;
		send_frame();
		frame(PROTO_IPV4, PROTO_IPV4, 34, '0, '0, 1'b1);
		frame(PROTO_IPV6, PROTO_IPV6, 14, '0, '0, 1'b0);
		wait_idle();

		write_register(REG_LEN_THRESHOLD, '0);
		write_register(REG_FILTER_ENABLE, '0);
		write_register(REG_SPARE_LO, rand64());
		write_register(REG_SPARE_HI, rand64());
		frame(PROTO_IPV4, PROTO_IPV4, 34, '0, '0, 1'b1);
		frame(PROTO_IPV4, PROTO_IPV4, 5, '0, '0, 1'b1);
		wait_idle();

		write_register(REG_FILTER_ENABLE, 64'd1);
		write_register(REG_ADDR_A_HIGH, '1);
		write_register(REG_ADDR_A_LOW, '1);
		write_register(REG_ADDR_B_HIGH, '0);
		write_register(REG_ADDR_B_LOW, '0);
		frame(PROTO_IPV6, PROTO_IPV6, 54, '1, '1, 1'b1);
		frame(PROTO_IPV4, PROTO_IPV4, 34, '0, 64'hffff_ffff, 1'b1);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			in_idle_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 28 : 0;
			out_stall_pct = (ph % 4 == 2) ? 59 : (ph % 4 == 3) ? 28 : 0;
			configure_phase(ph);
			if (ph == 0) begin
				hold_left = 40;
				repeat (12)
					frame(PROTO_IPV4, PROTO_IPV4, 1, '0, '0, 1'b1);
			end
			for (int n = 0; n < 2; n++) begin
				random_frame();
				if (n == 0)
					wait_idle();
			end
			wait_idle();
		end

		if (sb.pending_verdicts.size() != 0)
			sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
